>>> rtl/retransmit_timer_table_macros.svh
// Assertion macros shared by the timer table modules.
`ifndef RETRANSMIT_TIMER_TABLE_MACROS_SVH
`define RETRANSMIT_TIMER_TABLE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RTT_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define RTT_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rtt_pkg.sv
`timescale 1ns / 1ps
package rtt_pkg;
  localparam int unsigned OpcodeWidth = 2;
  localparam int unsigned EventIdWidth = 32;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    EV_RESEND = 2'd0,
    EV_DROP   = 2'd1,
    EV_ACCEPT = 2'd2,
    EV_REJECT = 2'd3
  } event_kind_t;

  typedef enum logic {
    REG_RETRY_GAP   = 1'b0,
    REG_RETRY_LIMIT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] message_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [3:0]  slot_index;
    logic [31:0] event_id;
    logic        last_of_run;
  } out_item_t;
endpackage

>>> rtl/rtt_fifo.sv
`timescale 1ns / 1ps
module rtt_fifo
  import rtt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t push_data,
  output logic     full,
  input  logic     pop,
  output in_item_t pop_data,
  output logic     not_empty
);
  in_item_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && not_empty) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push && !full} - {1'b0, pop && not_empty};
    end
  end
endmodule

>>> rtl/rtt_front.sv
`timescale 1ns / 1ps
module rtt_front
  import rtt_pkg::*;
#(
  parameter int unsigned ID_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  output logic     q_push,
  output in_item_t q_data,
  input  logic     q_full
);
  // Opcode three is dropped here; ids are cut to ID_BITS.
  localparam logic [31:0] IdMask = (ID_BITS >= 32) ? 32'hFFFF_FFFF
                                 : ((32'd1 << ID_BITS) - 32'd1);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && (in_data.opcode != OP_NONE);

  always_comb begin
    q_data            = in_data;
    q_data.message_id = in_data.message_id & IdMask;
  end

  `include "retransmit_timer_table_macros.svh"
  `RTT_ASSERT_IMP(a_no_push_full, clk, rst, q_full, !q_push, "push into full queue")
  `RTT_ASSERT_IMP(a_no_op3, clk, rst, q_push, q_data.opcode != OP_NONE, "opcode three queued")
  `RTT_ASSERT_IMP(a_push_valid, clk, rst, q_push, in_valid, "push without valid")
endmodule

>>> rtl/rtt_back.sv
`timescale 1ns / 1ps
module rtt_back
  import rtt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [0:0] cfg_idx,
  input  logic      cfg_hit,
  input  logic [15:0] cfg_data,
  input  logic      q_valid,
  input  in_item_t  q_data,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);
  localparam int unsigned SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned IdxW = SW + 1;
  localparam logic [SW:0] LastSlot = IdxW'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_TICK, S_EMIT} state_t;

  state_t state;
  logic [15:0] retry_gap;
  logic [7:0]  retry_limit;
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [31:0] entry_id      [TABLE_DEPTH];
  logic [31:0] entry_sent_at [TABLE_DEPTH];
  logic        entry_unsent  [TABLE_DEPTH];
  logic [7:0]  entry_tries   [TABLE_DEPTH];
  logic [31:0] time_now;
  in_item_t    cur;
  logic [SW:0] idx;
  logic        found;
  logic [SW-1:0] match_slot;
  logic        have_free;
  logic [SW-1:0] free_slot;
  logic        pend;
  out_item_t   pend_item;

  logic [SW-1:0] s;
  logic [31:0]   age;
  logic          due;
  logic          match;
  logic          out_free;
  logic [SW-1:0] put_slot;
  logic          out_load;
  out_item_t     out_next;

  assign s        = idx[SW-1:0];
  assign age      = time_now - entry_sent_at[s];
  assign due      = entry_valid[s] && (entry_unsent[s] || (age > {16'd0, retry_gap}));
  assign match    = entry_valid[s] && (entry_id[s] == cur.message_id);
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign put_slot = found ? match_slot : free_slot;

  // Decides whether the output register takes a new transaction this cycle.
  always_comb begin
    out_load = 1'b0;
    out_next = pend_item;
    case (state)
      S_EMIT: begin
        if (cur.opcode != OP_ACK && out_free) begin
          out_load             = 1'b1;
          out_next.event_id    = cur.message_id;
          out_next.last_of_run = 1'b1;
          if (found || have_free) begin
            out_next.event_kind = EV_ACCEPT;
            out_next.slot_index = 4'(put_slot);
          end else begin
            out_next.event_kind = EV_REJECT;
            out_next.slot_index = 4'd0;
          end
        end
      end
      S_TICK: begin
        if (idx > LastSlot) begin
          if (pend && out_free) begin
            out_load             = 1'b1;
            out_next.last_of_run = 1'b1;
          end
        end else if (due && pend && out_free) begin
          out_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Send and ack search one slot a cycle; a tick walks one slot a cycle while the
  // output does not stall and holds each due result pending so the last one can be marked.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      retry_gap   <= 16'd5;
      retry_limit <= 8'd5;
      entry_valid <= '0;
      time_now    <= 32'd0;
      out_valid   <= 1'b0;
      pend        <= 1'b0;
      idx         <= '0;
      found       <= 1'b0;
      have_free   <= 1'b0;
    end else begin
      if (cfg_we && cfg_hit) begin
        case (cfg_idx)
          REG_RETRY_GAP:   retry_gap <= cfg_data;
          REG_RETRY_LIMIT: retry_limit <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
        out_data  <= out_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur       <= q_data;
            idx       <= '0;
            found     <= 1'b0;
            have_free <= 1'b0;
            pend      <= 1'b0;
            if (q_data.opcode == OP_TICK) begin
              time_now <= time_now + 32'd1;
              state    <= S_TICK;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match && !found) begin
            found      <= 1'b1;
            match_slot <= s;
          end
          if (!entry_valid[s] && !have_free) begin
            have_free <= 1'b1;
            free_slot <= s;
          end
          if (idx == LastSlot) state <= S_EMIT;
          else idx <= idx + 1'b1;
        end
        S_EMIT: begin
          if (cur.opcode == OP_ACK) begin
            if (found) entry_valid[match_slot] <= 1'b0;
            state <= S_IDLE;
          end else if (out_free) begin
            if (found || have_free) begin
              entry_valid[put_slot]   <= 1'b1;
              entry_id[put_slot]      <= cur.message_id;
              entry_sent_at[put_slot] <= 32'd0;
              entry_unsent[put_slot]  <= 1'b1;
              entry_tries[put_slot]   <= 8'd0;
            end
            state <= S_IDLE;
          end
        end
        S_TICK: begin
          if (idx > LastSlot) begin
            if (!pend || out_free) begin
              pend  <= 1'b0;
              state <= S_IDLE;
            end
          end else if (!due) begin
            idx <= idx + 1'b1;
          end else if (!pend || out_free) begin
            pend                  <= 1'b1;
            pend_item.slot_index  <= 4'(s);
            pend_item.event_id    <= entry_id[s];
            pend_item.last_of_run <= 1'b0;
            if (entry_tries[s] < retry_limit) begin
              pend_item.event_kind <= EV_RESEND;
              entry_sent_at[s]     <= time_now;
              entry_tries[s]       <= entry_tries[s] + 8'd1;
              entry_unsent[s]      <= 1'b0;
            end else begin
              pend_item.event_kind <= EV_DROP;
              entry_valid[s]       <= 1'b0;
            end
            idx <= idx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "retransmit_timer_table_macros.svh"
  `RTT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "result changed under stall")
  `RTT_ASSERT_IMP(a_pop_idle, clk, rst, q_pop, state == S_IDLE, "pop while busy")
  `RTT_ASSERT_IMP(a_pend_tick, clk, rst, pend, state == S_TICK, "pending result outside tick")
endmodule

>>> rtl/retransmit_timer_table.sv
`timescale 1ns / 1ps
// Retransmission timer table.
// Input channel in_valid/in_stall/in_data carries one transaction per item:
// send (insert id), ack (free id) or tick (advance time, scan for due slots).
// Output channel out_valid/out_stall/out_data carries the resulting events:
// one accept or reject per send, none per ack, one resend or drop per due
// slot on a tick, the last of a tick's events marked by last_of_run.
// A two-entry queue sits between the accepting front and the table engine.
// Send and ack walk the table one slot per cycle in the engine; a tick does
// the same while the output does not stall, and a send result also waits for
// a free output register. The engine takes the next queued transaction only
// once it is idle again.
// Configuration: cfg_we/cfg_index/cfg_data, to be written only while idle; the block does not enforce this.
// Synchronous reset empties the table, zeroes time, sets both registers to 5.
// A stalled receiver holds the output register; the engine waits and the
// queue then fills and raises in_stall.
module retransmit_timer_table
  import rtt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic     q_push, q_full, q_pop, q_valid;
  in_item_t q_in, q_out;

  rtt_front #(.ID_BITS(ID_BITS)) u_front (
    .clk, .rst, .in_valid, .in_data, .in_stall,
    .q_push, .q_data(q_in), .q_full
  );

  rtt_fifo u_fifo (
    .clk, .rst, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .pop_data(q_out), .not_empty(q_valid)
  );

  rtt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst, .cfg_we, .cfg_idx(cfg_index), .cfg_hit(1'b1), .cfg_data,
    .q_valid, .q_data(q_out), .q_pop,
    .out_valid, .out_data, .out_stall
  );
endmodule
